>>> src/m3sa_pkg.sv
// ----------------------------------------------------------------------------
// m3sa_pkg
// Shared widths, codes and inter-module types for the median-of-three
// smoothed average block.
// ----------------------------------------------------------------------------
package m3sa_pkg;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int TOTAL_W  = 7;
    localparam int CFG_W    = 6;
    localparam int KIND_W   = 2;
    // sum of up to 62 medians of 24-bit samples
    localparam int SUM_W    = SAMPLE_W + CFG_W;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;

    // defaults
    localparam int               MAX_WINDOW_DEF = 63;
    localparam logic [CFG_W-1:0] WINDOW_RST     = 6'd10;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // control into the median accumulator
    typedef struct packed {
        logic clear;
        logic valid;
    } med_ctl_t;

    // status out of the divider
    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] quotient;
    } div_res_t;

endpackage

>>> src/median3_smoothed_average.sv
// ----------------------------------------------------------------------------
// median3_smoothed_average
// Restart: RAM read, then write to entry 0.
// Report with n >= 3 samples: the window is read through the single RAM
// read port (one sample per cycle), then the 1-bit-per-cycle divider (30
// steps) forms the average. Report with fewer samples skips both.
// A stalled result waits in the hold state.
// One request is in work at a time.
// Reset (aresetn, synchronous) empties the window and sets window_size to 10.
// ----------------------------------------------------------------------------
module median3_smoothed_average #(
    parameter int MAX_WINDOW = m3sa_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [m3sa_pkg::KIND_W-1:0]          s_kind,
    input  logic signed [m3sa_pkg::SAMPLE_W-1:0] s_sample,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [m3sa_pkg::SAMPLE_W-1:0] m_filtered_value,
    output logic [m3sa_pkg::TOTAL_W-1:0]         m_sample_total,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [m3sa_pkg::PADDR_W-1:0]         paddr,
    input  logic [m3sa_pkg::PDATA_W-1:0]         pwdata,
    output logic [m3sa_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int DEPTH = MAX_WINDOW + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = m3sa_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIRST,
        ST_HOLD,
        ST_RST_WR
    } state_t;

    state_t                               state_reg;
    logic [TW-1:0]                        fill_reg;
    logic [m3sa_pkg::CFG_W-1:0]           ws_reg;
    logic [TW-1:0]                        scan_reg;
    logic                                 rd_vld_reg;
    logic signed [m3sa_pkg::SAMPLE_W-1:0] res_reg;
    logic                                 m_valid_reg;
    logic signed [m3sa_pkg::SAMPLE_W-1:0] m_value_reg;
    logic [TW-1:0]                        m_total_reg;

    logic [TW-1:0]                        fill_next;
    logic [TW-1:0]                        cap;
    logic                                 accept;
    logic                                 cfg_wr;
    logic                                 cfg_new;
    logic                                 room;
    logic                                 ram_we;
    logic [AW-1:0]                        ram_waddr;
    logic [m3sa_pkg::SAMPLE_W-1:0]        ram_wdata;
    logic [AW-1:0]                        ram_raddr;
    logic [m3sa_pkg::SAMPLE_W-1:0]        ram_rdata;
    m3sa_pkg::med_ctl_t                   med_ctl;
    logic signed [m3sa_pkg::SUM_W-1:0]    med_sum;
    m3sa_pkg::div_res_t                   div_res;
    logic                                 out_free;

    // handshake decode and window capacity
    always_comb begin
        cap      = (int'(ws_reg) > MAX_WINDOW) ? TW'(MAX_WINDOW) : TW'(ws_reg);
        accept   = s_valid && s_ready;
        cfg_wr   = psel && penable && pwrite &&
                   (paddr[m3sa_pkg::PADDR_W-1:2] == m3sa_pkg::REG_WINDOW_SIZE);
        cfg_new  = cfg_wr && (pwdata[m3sa_pkg::CFG_W-1:0] != ws_reg);
        room     = (fill_reg <= cap);
        out_free = !m_valid_reg || m_ready;
    end

    // next fill count; a new window size empties the window
    always_comb begin
        fill_next = fill_reg;
        if (accept && (s_kind == m3sa_pkg::KIND_ADD) && room) begin
            fill_next = fill_reg + TW'(1);
        end
        if (state_reg == ST_RST_WR) begin
            fill_next = TW'(1);
        end
        if (cfg_new) begin
            fill_next = '0;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign pready  = 1'b1;

    // register read back
    always_comb begin
        prdata = '0;
        if (paddr[m3sa_pkg::PADDR_W-1:2] == m3sa_pkg::REG_WINDOW_SIZE) begin
            prdata = m3sa_pkg::PDATA_W'(ws_reg);
        end
    end

    // RAM access selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(fill_reg);
        ram_wdata = s_sample;
        ram_raddr = '0;
        case (state_reg)
            ST_IDLE: begin
                ram_we = accept && (s_kind == m3sa_pkg::KIND_ADD) && room;
                if (accept && (s_kind == m3sa_pkg::KIND_RESTART)) begin
                    ram_raddr = AW'(fill_reg - TW'(1));
                end
            end
            ST_SCAN: begin
                ram_raddr = AW'(scan_reg);
            end
            ST_RST_WR: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // median accumulator control
    assign med_ctl.clear = accept && (s_kind == m3sa_pkg::KIND_REPORT);
    assign med_ctl.valid = rd_vld_reg;

    m3sa_ram #(
        .WIDTH (m3sa_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    m3sa_med_acc u_med (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (med_ctl),
        .din     ($signed(ram_rdata)),
        .sum     (med_sum)
    );

    m3sa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIV_GO),
        .dividend (med_sum),
        .divisor  (fill_reg - TW'(2)),
        .res      (div_res)
    );

    // sequencer, window state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            ws_reg      <= m3sa_pkg::WINDOW_RST;
            scan_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            // a RAM read issued this cycle reaches the accumulator next cycle
            rd_vld_reg <= (state_reg == ST_SCAN) ||
                          (accept && (s_kind == m3sa_pkg::KIND_REPORT) &&
                           (fill_reg > TW'(2)));
            // result valid: set from the hold state, cleared when taken
            if ((state_reg == ST_HOLD) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_kind)
                            m3sa_pkg::KIND_REPORT: begin
                                if (fill_reg > TW'(2)) begin
                                    // entry 0 is read this cycle
                                    scan_reg   <= TW'(1);
                                    state_reg  <= ST_SCAN;
                                end else if (fill_reg != '0) begin
                                    state_reg <= ST_FIRST;
                                end else begin
                                    res_reg   <= '0;
                                    state_reg <= ST_HOLD;
                                end
                            end
                            m3sa_pkg::KIND_RESTART: begin
                                if (fill_reg != '0) begin
                                    state_reg <= ST_RST_WR;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    scan_reg   <= scan_reg + TW'(1);
                    if (scan_reg == fill_reg - TW'(1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // last sample enters the accumulator at this edge
                    state_reg <= ST_DIV_GO;
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_res.done) begin
                        res_reg   <= div_res.quotient[m3sa_pkg::SAMPLE_W-1:0];
                        state_reg <= ST_HOLD;
                    end
                end
                ST_FIRST: begin
                    res_reg   <= $signed(ram_rdata);
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (out_free) begin
                        m_value_reg <= res_reg;
                        m_total_reg <= fill_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_RST_WR: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // a new window size
            if (cfg_new) begin
                ws_reg <= pwdata[m3sa_pkg::CFG_W-1:0];
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_value = m_value_reg;
    assign m_sample_total   = m_total_reg;

`ifndef NO_ASSERTIONS
    // window never holds more than the RAM depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= DEPTH)
        else $error("fill count beyond window depth");

    // an accepted add with room grows the window by one
    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_kind == m3sa_pkg::KIND_ADD) && room && !cfg_wr)
        |=> (fill_reg == $past(fill_reg) + TW'(1)))
        else $error("add request did not grow the window");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider result outside the wait state");

    // a restart leaves exactly one sample
    a_restart_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RST_WR && !cfg_wr) |=> (fill_reg == TW'(1)))
        else $error("restart did not keep one sample");
`endif

endmodule

>>> src/m3sa_ram.sv
// ----------------------------------------------------------------------------
// m3sa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module m3sa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/m3sa_med_acc.sv
// ----------------------------------------------------------------------------
// m3sa_med_acc
// Takes the sample stream read from the window and accumulates the median
// of every three neighboring samples.
// ----------------------------------------------------------------------------
module m3sa_med_acc (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  m3sa_pkg::med_ctl_t                  ctl,
    input  logic signed [m3sa_pkg::SAMPLE_W-1:0] din,
    output logic signed [m3sa_pkg::SUM_W-1:0]    sum
);

    logic signed [m3sa_pkg::SAMPLE_W-1:0] a_reg;
    logic signed [m3sa_pkg::SAMPLE_W-1:0] b_reg;
    logic signed [m3sa_pkg::SUM_W-1:0]    sum_reg;
    logic [1:0]                           cnt_reg;

    logic signed [m3sa_pkg::SAMPLE_W-1:0] lo_ab;
    logic signed [m3sa_pkg::SAMPLE_W-1:0] hi_ab;
    logic signed [m3sa_pkg::SAMPLE_W-1:0] lo_hc;
    logic signed [m3sa_pkg::SAMPLE_W-1:0] mid;

    // median = max(min(a,b), min(max(a,b),c))
    always_comb begin
        lo_ab = (a_reg < b_reg) ? a_reg : b_reg;
        hi_ab = (a_reg < b_reg) ? b_reg : a_reg;
        lo_hc = (hi_ab < din) ? hi_ab : din;
        mid   = (lo_ab > lo_hc) ? lo_ab : lo_hc;
    end

    // two-sample history and running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            sum_reg <= '0;
        end else if (ctl.clear) begin
            cnt_reg <= 2'd0;
            sum_reg <= '0;
        end else if (ctl.valid) begin
            a_reg <= b_reg;
            b_reg <= din;
            if (cnt_reg == 2'd2) begin
                sum_reg <= sum_reg + m3sa_pkg::SUM_W'(mid);
            end else begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    assign sum = sum_reg;

endmodule

>>> src/m3sa_div.sv
// ----------------------------------------------------------------------------
// m3sa_div
// Restoring divider, one quotient bit per cycle: signed dividend by an
// unsigned count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module m3sa_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [m3sa_pkg::SUM_W-1:0]    dividend,
    input  logic [m3sa_pkg::TOTAL_W-1:0]         divisor,
    output m3sa_pkg::div_res_t                   res
);

    localparam int CNT_W = $clog2(m3sa_pkg::SUM_W);

    logic                           busy_reg;
    logic                           done_reg;
    logic                           neg_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [m3sa_pkg::SUM_W-1:0]     quo_reg;
    logic [m3sa_pkg::TOTAL_W-1:0]   rem_reg;
    logic [m3sa_pkg::TOTAL_W-1:0]   div_reg;

    logic [m3sa_pkg::SUM_W-1:0]     mag;
    logic [m3sa_pkg::TOTAL_W:0]     shifted;
    logic [m3sa_pkg::TOTAL_W:0]     diff;
    logic                           qbit;
    logic [m3sa_pkg::TOTAL_W-1:0]   rem_next;

    // magnitude of the dividend and one restoring step
    always_comb begin
        mag      = dividend[m3sa_pkg::SUM_W-1] ? m3sa_pkg::SUM_W'(-dividend)
                                               : m3sa_pkg::SUM_W'(dividend);
        shifted  = {rem_reg, quo_reg[m3sa_pkg::SUM_W-1]};
        diff     = shifted - {1'b0, div_reg};
        qbit     = (shifted >= {1'b0, div_reg});
        rem_next = qbit ? diff[m3sa_pkg::TOTAL_W-1:0] : shifted[m3sa_pkg::TOTAL_W-1:0];
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // one-cycle pulse after the last step
            done_reg <= busy_reg && !start &&
                        (cnt_reg == CNT_W'(m3sa_pkg::SUM_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= mag;
                rem_reg  <= '0;
                div_reg  <= divisor;
                neg_reg  <= dividend[m3sa_pkg::SUM_W-1];
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[m3sa_pkg::SUM_W-2:0], qbit};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(m3sa_pkg::SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for median3_smoothed_average. Requests (add, report,
// restart and the unused kind) are driven in random bursts while the result
// side stalls on its own pattern. A scoreboard keeps a shadow copy of the
// sample window, predicts each report and compares every returned field.
// window_size is rewritten between phases over its extremes and random values.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [m3sa_pkg::KIND_W-1:0] KIND_IGNORED  = 2'd3;
    localparam int                WINDOW_LIMIT  = m3sa_pkg::MAX_WINDOW_DEF;
    localparam int                REG_UNKNOWN   = 1;
    localparam int                RANDOM_ITEMS  = 950;
    localparam int                PHASES        = 7;
    localparam int                SETTLE_CYCLES = 16;
    localparam int                END_CYCLES    = 150;
    localparam int                IDLE_LIMIT    = 3000;

    logic                                 aclk;
    logic                                 aresetn  = 1'b0;
    logic                                 s_valid  = 1'b0;
    logic                                 s_ready;
    logic [m3sa_pkg::KIND_W-1:0]          s_kind   = m3sa_pkg::KIND_ADD;
    logic signed [m3sa_pkg::SAMPLE_W-1:0] s_sample = '0;
    logic                                 m_valid;
    logic                                 m_ready  = 1'b0;
    logic signed [m3sa_pkg::SAMPLE_W-1:0] m_filtered_value;
    logic [m3sa_pkg::TOTAL_W-1:0]         m_sample_total;
    logic                                 psel     = 1'b0;
    logic                                 penable  = 1'b0;
    logic                                 pwrite   = 1'b0;
    logic [m3sa_pkg::PADDR_W-1:0]         paddr    = '0;
    logic [m3sa_pkg::PDATA_W-1:0]         pwdata   = '0;
    logic [m3sa_pkg::PDATA_W-1:0]         prdata;
    logic                                 pready;

    median3_smoothed_average uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_sample_total   (m_sample_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    typedef struct {
        logic signed [m3sa_pkg::SAMPLE_W-1:0] level;
        logic [m3sa_pkg::TOTAL_W-1:0]         count;
    } report_t;

    // Shadow window plus the queue of reports still owed by the block
    class smoothing_scoreboard;
        logic signed [m3sa_pkg::SAMPLE_W-1:0] held[$];
        logic [m3sa_pkg::CFG_W-1:0]           window_size = m3sa_pkg::WINDOW_RST;
        report_t                              report_q[$];
        int                                   errors = 0;

        function int pending();
            return report_q.size();
        endfunction

        function logic signed [m3sa_pkg::SAMPLE_W-1:0] median_of_three(
            logic signed [m3sa_pkg::SAMPLE_W-1:0] a,
            logic signed [m3sa_pkg::SAMPLE_W-1:0] b,
            logic signed [m3sa_pkg::SAMPLE_W-1:0] c);
            if (a > b) begin
                if (b > c) return b;
                return (a > c) ? c : a;
            end
            if (a > c) return a;
            return (b > c) ? c : b;
        endfunction

        // average of the sliding medians, truncated toward zero
        function logic signed [m3sa_pkg::SAMPLE_W-1:0] smoothed_level();
            longint total;
            int     n;
            total = 0;
            n     = held.size();
            if (n > 2) begin
                for (int i = 1; i + 1 < n; i++)
                    total += longint'(median_of_three(held[i-1], held[i], held[i+1]));
                return m3sa_pkg::SAMPLE_W'(total / longint'(n - 2));
            end
            if (n > 0) return held[0];
            return '0;
        endfunction

        function void write_register(int unsigned reg_idx,
                                     logic [m3sa_pkg::PDATA_W-1:0] wdata);
            if (reg_idx != m3sa_pkg::REG_WINDOW_SIZE) return;
            // rewriting the current size leaves the window alone
            if (wdata[m3sa_pkg::CFG_W-1:0] == window_size) return;
            window_size = wdata[m3sa_pkg::CFG_W-1:0];
            held.delete();
        endfunction

        function void note_request(logic [m3sa_pkg::KIND_W-1:0] kind,
                                   logic signed [m3sa_pkg::SAMPLE_W-1:0] sample);
            int      cap;
            report_t rep;
            cap = (window_size > WINDOW_LIMIT) ? WINDOW_LIMIT : window_size;
            case (kind)
                m3sa_pkg::KIND_ADD: begin
                    // full window drops the sample
                    if (held.size() <= cap) held.push_back(sample);
                end
                m3sa_pkg::KIND_REPORT: begin
                    rep.level = smoothed_level();
                    rep.count = m3sa_pkg::TOTAL_W'(held.size());
                    report_q.push_back(rep);
                end
                m3sa_pkg::KIND_RESTART: begin
                    if (held.size() > 0) held = '{held[$]};
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [m3sa_pkg::SAMPLE_W-1:0] level,
                                   logic [m3sa_pkg::TOTAL_W-1:0] count);
            report_t rep;
            if (report_q.size() == 0) begin
                $error("unexpected result: filtered_value %0d, sample_total %0d",
                       level, count);
                errors++;
                return;
            end
            rep = report_q.pop_front();
            if (level !== rep.level) begin
                $error("filtered_value: expected %0d, got %0d", rep.level, level);
                errors++;
            end
            if (count !== rep.count) begin
                $error("sample_total: expected %0d, got %0d", rep.count, count);
                errors++;
            end
        endfunction
    endclass

    smoothing_scoreboard sb = new;

    int          burst_left  = 0;
    int          sent_items  = 0;
    int          idle_cycles = 0;
    logic [15:0] ready_pattern = '1;
    int          pattern_pos   = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // monitor both channels; results first since they stem from older requests
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_filtered_value, m_sample_total);
            if (s_valid && s_ready) sb.note_request(s_kind, s_sample);
        end
    end

    // result side back-pressure, a fresh 16-bit ready pattern each round
    always @(negedge aclk) begin
        if (pattern_pos == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = '1;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'($urandom | $urandom);
                default: ready_pattern = 16'h8000;
            endcase
        end
        m_ready <= ready_pattern[pattern_pos];
        pattern_pos = (pattern_pos + 1) % 16;
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [m3sa_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(m3sa_pkg::SAMPLE_W-1){1'b0}}};
            1: return {1'b0, {(m3sa_pkg::SAMPLE_W-1){1'b1}}};
            2: return m3sa_pkg::SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
            default: return m3sa_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // one request; called at a falling edge, returns at a falling edge
    task automatic send_request(input logic [m3sa_pkg::KIND_W-1:0] kind,
                                input logic signed [m3sa_pkg::SAMPLE_W-1:0] sample);
        s_valid  = 1'b1;
        s_kind   = kind;
        s_sample = sample;
        do @(posedge aclk); while (!s_ready);
        if (kind != KIND_IGNORED) sent_items++;
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid  = 1'b0;
            s_kind   = m3sa_pkg::KIND_W'($urandom);
            s_sample = m3sa_pkg::SAMPLE_W'($urandom);
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 4))
                @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    // drop valid, collect every owed report, let adds and restarts finish
    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_access(input logic write_en, input int unsigned reg_idx,
                              input logic [m3sa_pkg::PDATA_W-1:0] wdata,
                              output logic [m3sa_pkg::PDATA_W-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write_en;
        paddr   = m3sa_pkg::PADDR_W'(reg_idx << 2);
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (write_en) sb.write_register(reg_idx, wdata);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_window_readback();
        logic [m3sa_pkg::PDATA_W-1:0] readback;
        apb_access(1'b0, m3sa_pkg::REG_WINDOW_SIZE, '0, readback);
        if (readback !== m3sa_pkg::PDATA_W'(sb.window_size)) begin
            $error("window_size readback: expected %0d, got %0d", sb.window_size, readback);
            sb.errors++;
        end
    endtask

    task automatic set_window(input int unsigned reg_idx,
                              input logic [m3sa_pkg::PDATA_W-1:0] wdata);
        logic [m3sa_pkg::PDATA_W-1:0] unused_rdata;
        wait_idle();
        apb_access(1'b1, reg_idx, wdata, unused_rdata);
        check_window_readback();
    endtask

    initial begin
        int cap;
        int len;
        int choice;
        int phase_end;
        int size;

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        check_window_readback();

        // empty window, restart on empty, first sample, two samples
        send_request(m3sa_pkg::KIND_REPORT, '0);
        send_request(m3sa_pkg::KIND_RESTART, '0);
        send_request(m3sa_pkg::KIND_REPORT, '0);
        send_request(m3sa_pkg::KIND_ADD, {1'b1, {(m3sa_pkg::SAMPLE_W-1){1'b0}}});
        send_request(m3sa_pkg::KIND_REPORT, '0);
        send_request(m3sa_pkg::KIND_ADD, {1'b0, {(m3sa_pkg::SAMPLE_W-1){1'b1}}});
        send_request(m3sa_pkg::KIND_REPORT, '0);
        send_request(m3sa_pkg::KIND_ADD, '0);
        send_request(m3sa_pkg::KIND_REPORT, '0);
        // unused kind must be ignored
        send_request(KIND_IGNORED, {1'b0, {(m3sa_pkg::SAMPLE_W-1){1'b1}}});
        // restart keeps the zero; negative average truncates toward zero
        send_request(m3sa_pkg::KIND_RESTART, '0);
        send_request(m3sa_pkg::KIND_ADD, -24'sd1);
        send_request(m3sa_pkg::KIND_ADD, -24'sd5);
        send_request(m3sa_pkg::KIND_ADD, -24'sd4);
        send_request(m3sa_pkg::KIND_REPORT, '0);

        // two-sample window: third sample dropped
        set_window(m3sa_pkg::REG_WINDOW_SIZE, 32'd1);
        send_request(m3sa_pkg::KIND_ADD, {1'b0, {(m3sa_pkg::SAMPLE_W-1){1'b1}}});
        send_request(m3sa_pkg::KIND_ADD, {1'b1, {(m3sa_pkg::SAMPLE_W-1){1'b0}}});
        send_request(m3sa_pkg::KIND_ADD, 24'sd1);
        send_request(m3sa_pkg::KIND_REPORT, '0);
        // same size and an unknown register leave the window intact
        set_window(m3sa_pkg::REG_WINDOW_SIZE, 32'd1);
        set_window(REG_UNKNOWN, 32'd5);
        send_request(m3sa_pkg::KIND_REPORT, '0);

        // size zero holds one sample
        set_window(m3sa_pkg::REG_WINDOW_SIZE, 32'd0);
        send_request(m3sa_pkg::KIND_ADD, 24'sd7);
        send_request(m3sa_pkg::KIND_ADD, 24'sd8);
        send_request(m3sa_pkg::KIND_REPORT, '0);
        send_request(m3sa_pkg::KIND_RESTART, '0);
        send_request(m3sa_pkg::KIND_REPORT, '0);

        // random phases over several window sizes
        phase_end = sent_items;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: size = 1;
                1: size = WINDOW_LIMIT;
                2: size = 0;
                3: size = 2;
                default: size = $urandom_range(0, WINDOW_LIMIT);
            endcase
            if ($urandom_range(0, 1) == 0)
                set_window(m3sa_pkg::REG_WINDOW_SIZE, m3sa_pkg::PDATA_W'(size));
            else
                set_window(m3sa_pkg::REG_WINDOW_SIZE,
                           ($urandom & ~32'h3F) | m3sa_pkg::PDATA_W'(size));
            phase_end += RANDOM_ITEMS / PHASES;
            while (sent_items < phase_end) begin
                cap    = (sb.window_size > WINDOW_LIMIT) ? WINDOW_LIMIT : sb.window_size;
                choice = $urandom_range(0, 99);
                if (choice < 65) begin
                    // fill run, then report, sometimes restart
                    case ($urandom_range(0, 3))
                        0: len = cap + 1 + $urandom_range(0, 3);
                        1: len = $urandom_range(0, cap + 3);
                        default: len = $urandom_range(0, 6);
                    endcase
                    repeat (len) send_request(m3sa_pkg::KIND_ADD, random_sample());
                    send_request(m3sa_pkg::KIND_REPORT, random_sample());
                    if ($urandom_range(0, 1) == 0)
                        send_request(m3sa_pkg::KIND_RESTART, random_sample());
                end else if (choice < 80) begin
                    send_request(m3sa_pkg::KIND_RESTART, random_sample());
                    send_request(m3sa_pkg::KIND_REPORT, random_sample());
                end else if (choice < 90) begin
                    send_request(m3sa_pkg::KIND_REPORT, random_sample());
                end else begin
                    send_request(m3sa_pkg::KIND_W'($urandom), random_sample());
                end
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
src/m3sa_pkg.sv
src/m3sa_ram.sv
src/m3sa_med_acc.sv
src/m3sa_div.sv
src/median3_smoothed_average.sv
sim/testbench.sv
